### design/panel_switch_debounce_and_encoder_decode_top_macros.svh
// Assertion macros shared by the checker.
`ifndef PANEL_SWITCH_DEBOUNCE_AND_ENCODER_DECODE_TOP_MACROS_SVH
`define PANEL_SWITCH_DEBOUNCE_AND_ENCODER_DECODE_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PDENC_ASSERT_NOW(label, cond, conseq) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (conseq)) \
		else $error("pdenc assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define PDENC_ASSERT_NEXT(label, cond, conseq) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (conseq)) \
		else $error("pdenc assertion failed");

`endif

### design/pdenc_pkg.sv
package pdenc_pkg;

	localparam int SWITCH_COUNT  = 3;
	localparam int ENCODER_COUNT = 3;
	localparam int TOTAL_WIDTH   = 16;
	localparam int COUNT_WIDTH   = 4;
	localparam int PHASE_WIDTH   = 2;

	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX      = '1;
	localparam logic [COUNT_WIDTH-1:0] DEBOUNCE_RESET = COUNT_WIDTH'(3);

	localparam logic [TOTAL_WIDTH-1:0] TOTAL_MAX = {1'b0, {(TOTAL_WIDTH-1){1'b1}}};
	localparam logic [TOTAL_WIDTH-1:0] TOTAL_MIN = {1'b1, {(TOTAL_WIDTH-1){1'b0}}};

	// step per {last phase, current phase}; -1 coded as 2'b11
	localparam logic [1:0] QUAD_TABLE [0:15] = '{
		2'b00, 2'b11, 2'b01, 2'b00, 2'b01, 2'b00, 2'b00, 2'b11,
		2'b11, 2'b00, 2'b00, 2'b01, 2'b00, 2'b01, 2'b11, 2'b00
	};

	typedef struct packed {
		logic held;
		logic press;
	} sw_lane_t;

	typedef struct packed {
		logic [TOTAL_WIDTH-1:0] delta;
	} enc_lane_t;

	typedef struct packed {
		logic [SWITCH_COUNT-1:0]                      held_mask;
		logic [SWITCH_COUNT-1:0]                      press_mask;
		logic [ENCODER_COUNT-1:0][TOTAL_WIDTH-1:0]    deltas;
	} result_t;

endpackage

### design/pdenc_switch_lane.sv
module pdenc_switch_lane (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             accept,
	input  logic                             level,
	input  logic                             take,
	input  logic [pdenc_pkg::COUNT_WIDTH-1:0] debounce,
	output pdenc_pkg::sw_lane_t              status
);

	logic                             stable_q;
	logic                             flag_q;
	logic [pdenc_pkg::COUNT_WIDTH-1:0] count_q;
	logic [pdenc_pkg::COUNT_WIDTH-1:0] count_inc;
	logic                             raw;
	logic                             differ;
	logic                             flip;

	always_comb begin
		raw       = ~level;
		differ    = raw != stable_q;
		count_inc = (count_q == pdenc_pkg::COUNT_MAX) ? count_q
			: count_q + pdenc_pkg::COUNT_WIDTH'(1);
		flip         = differ && (count_inc >= debounce);
		status.held  = flip ? raw : stable_q;
		status.press = take & flag_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q <= 1'b0;
			flag_q   <= 1'b0;
			count_q  <= '0;
		end else if (accept) begin
			if (flip) begin
				stable_q <= raw;
				flag_q   <= raw;
				count_q  <= '0;
			end else begin
				flag_q  <= flag_q & ~take;
				count_q <= differ ? count_inc : '0;
			end
		end
	end

endmodule

### design/pdenc_encoder_lane.sv
module pdenc_encoder_lane (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic                  enc_clock,
	input  logic                  enc_data,
	input  logic                  take,
	output pdenc_pkg::enc_lane_t  status
);

	localparam int TW = pdenc_pkg::TOTAL_WIDTH;

	logic [pdenc_pkg::PHASE_WIDTH-1:0] last_q;
	logic [pdenc_pkg::PHASE_WIDTH-1:0] phase;
	logic [TW-1:0]                     total_q;
	logic [TW-1:0]                     base;
	logic [TW-1:0]                     total_next;
	logic [1:0]                        step;
	logic [TW:0]                       sum;

	always_comb begin
		phase = {enc_clock, enc_data};
		step  = pdenc_pkg::QUAD_TABLE[{last_q, phase}];
		base  = take ? '0 : total_q;
		sum   = {base[TW-1], base} + {{(TW-1){step[1]}}, step};
		if (sum[TW] != sum[TW-1]) begin
			total_next = sum[TW] ? pdenc_pkg::TOTAL_MIN : pdenc_pkg::TOTAL_MAX;
		end else begin
			total_next = sum[TW-1:0];
		end
		status.delta = take ? total_q : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q  <= '0;
			total_q <= '0;
		end else if (accept) begin
			last_q  <= phase;
			total_q <= total_next;
		end
	end

endmodule

### design/pdenc_merge.sv
module pdenc_merge (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic                  out_stall,
	input  pdenc_pkg::sw_lane_t   sw_status  [pdenc_pkg::SWITCH_COUNT],
	input  pdenc_pkg::enc_lane_t  enc_status [pdenc_pkg::ENCODER_COUNT],
	output pdenc_pkg::result_t    result,
	output logic                  out_valid,
	output logic                  in_stall
);

	pdenc_pkg::result_t merged;
	pdenc_pkg::result_t main_q;
	pdenc_pkg::result_t skid_q;
	logic               main_valid_q;
	logic               skid_valid_q;
	logic               pop;

	always_comb begin
		for (int i = 0; i < pdenc_pkg::SWITCH_COUNT; i++) begin
			merged.held_mask[i]  = sw_status[i].held;
			merged.press_mask[i] = sw_status[i].press;
		end
		for (int e = 0; e < pdenc_pkg::ENCODER_COUNT; e++) begin
			merged.deltas[e] = enc_status[e].delta;
		end
	end

	assign pop       = main_valid_q & ~out_stall;
	assign out_valid = main_valid_q;
	assign in_stall  = skid_valid_q;
	assign result    = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (pop && skid_valid_q) begin
				main_valid_q <= 1'b1;
				skid_valid_q <= push;
			end else if (!main_valid_q || pop) begin
				main_valid_q <= push;
			end else if (push) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && skid_valid_q) begin
			main_q <= skid_q;
			if (push) begin
				skid_q <= merged;
			end
		end else if (!main_valid_q || pop) begin
			if (push) begin
				main_q <= merged;
			end
		end else if (push) begin
			skid_q <= merged;
		end
	end

endmodule

### design/panel_switch_debounce_and_encoder_decode_top.sv
// Channel  | Handshake            | Payload
// ---------+----------------------+-------------------------------------------------
// input    | in_valid / in_stall  | switch_levels, encoder_clock, encoder_data,
//          |                      | take_delta_mask, take_press_mask
// output   | out_valid / out_stall| held_mask, press_mask, delta_first/second/third
// config   | cfg_we               | cfg_wdata (debounce_samples)
//
// One sample per cycle while in_stall is low; each lane updates its state in the accept cycle.
// The result is registered into a two-entry output buffer (main and skid entries) and shown from the main entry.
// in_stall rises only when both buffer entries are full under out_stall.
// Reset clears all lane state and sets debounce_samples to 3.
module panel_switch_debounce_and_encoder_decode_top (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [pdenc_pkg::COUNT_WIDTH-1:0]       cfg_wdata,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [pdenc_pkg::SWITCH_COUNT-1:0]      switch_levels,
	input  logic [pdenc_pkg::ENCODER_COUNT-1:0]     encoder_clock,
	input  logic [pdenc_pkg::ENCODER_COUNT-1:0]     encoder_data,
	input  logic [pdenc_pkg::ENCODER_COUNT-1:0]     take_delta_mask,
	input  logic [pdenc_pkg::SWITCH_COUNT-1:0]      take_press_mask,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [pdenc_pkg::SWITCH_COUNT-1:0]      held_mask,
	output logic [pdenc_pkg::SWITCH_COUNT-1:0]      press_mask,
	output logic signed [pdenc_pkg::TOTAL_WIDTH-1:0] delta_first,
	output logic signed [pdenc_pkg::TOTAL_WIDTH-1:0] delta_second,
	output logic signed [pdenc_pkg::TOTAL_WIDTH-1:0] delta_third
);

	logic [pdenc_pkg::COUNT_WIDTH-1:0] debounce_q;
	logic                              accept;
	pdenc_pkg::sw_lane_t               sw_status  [pdenc_pkg::SWITCH_COUNT];
	pdenc_pkg::enc_lane_t              enc_status [pdenc_pkg::ENCODER_COUNT];
	pdenc_pkg::result_t                result;

	assign accept = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= pdenc_pkg::DEBOUNCE_RESET;
		end else if (cfg_we) begin
			debounce_q <= cfg_wdata;
		end
	end

	for (genvar i = 0; i < pdenc_pkg::SWITCH_COUNT; i++) begin : g_switch
		pdenc_switch_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.accept   (accept),
			.level    (switch_levels[i]),
			.take     (take_press_mask[i]),
			.debounce (debounce_q),
			.status   (sw_status[i])
		);
	end

	for (genvar e = 0; e < pdenc_pkg::ENCODER_COUNT; e++) begin : g_encoder
		pdenc_encoder_lane u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.accept    (accept),
			.enc_clock (encoder_clock[e]),
			.enc_data  (encoder_data[e]),
			.take      (take_delta_mask[e]),
			.status    (enc_status[e])
		);
	end

	pdenc_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (accept),
		.out_stall  (out_stall),
		.sw_status  (sw_status),
		.enc_status (enc_status),
		.result     (result),
		.out_valid  (out_valid),
		.in_stall   (in_stall)
	);

	assign held_mask    = result.held_mask;
	assign press_mask   = result.press_mask;
	assign delta_first  = result.deltas[0];
	assign delta_second = result.deltas[1];
	assign delta_third  = result.deltas[2];

endmodule

### design/pdenc_checker.sv
`include "panel_switch_debounce_and_encoder_decode_top_macros.svh"

module pdenc_checker (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   in_valid,
	input logic                                   in_stall,
	input logic                                   out_valid,
	input logic                                   out_stall,
	input logic [pdenc_pkg::SWITCH_COUNT-1:0]      held_mask,
	input logic [pdenc_pkg::SWITCH_COUNT-1:0]      press_mask,
	input logic signed [pdenc_pkg::TOTAL_WIDTH-1:0] delta_first,
	input logic signed [pdenc_pkg::TOTAL_WIDTH-1:0] delta_second,
	input logic signed [pdenc_pkg::TOTAL_WIDTH-1:0] delta_third
);

	`PDENC_ASSERT_NOW(a_stall_needs_result, in_stall, out_valid)
	`PDENC_ASSERT_NEXT(a_request_shows_result, !out_valid && in_valid && !in_stall, out_valid)
	`PDENC_ASSERT_NEXT(a_result_held, out_valid && out_stall, out_valid)
	`PDENC_ASSERT_NEXT(a_payload_held, out_valid && out_stall, $stable(held_mask) && $stable(press_mask) && $stable(delta_first) && $stable(delta_second) && $stable(delta_third))

endmodule

bind panel_switch_debounce_and_encoder_decode_top pdenc_checker u_pdenc_checker (.*);

### test/panel_report_checker.sv
module panel_report_checker (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cfg_we,
	input  logic [pdenc_pkg::COUNT_WIDTH-1:0]        cfg_wdata,
	input  logic                                     in_valid,
	input  logic                                     in_stall,
	input  logic [pdenc_pkg::SWITCH_COUNT-1:0]       switch_levels,
	input  logic [pdenc_pkg::ENCODER_COUNT-1:0]      encoder_clock,
	input  logic [pdenc_pkg::ENCODER_COUNT-1:0]      encoder_data,
	input  logic [pdenc_pkg::ENCODER_COUNT-1:0]      take_delta_mask,
	input  logic [pdenc_pkg::SWITCH_COUNT-1:0]       take_press_mask,
	input  logic                                     out_valid,
	input  logic                                     out_stall,
	input  logic [pdenc_pkg::SWITCH_COUNT-1:0]       held_mask,
	input  logic [pdenc_pkg::SWITCH_COUNT-1:0]       press_mask,
	input  logic signed [pdenc_pkg::TOTAL_WIDTH-1:0] delta_first,
	input  logic signed [pdenc_pkg::TOTAL_WIDTH-1:0] delta_second,
	input  logic signed [pdenc_pkg::TOTAL_WIDTH-1:0] delta_third,
	output int                                       mismatches,
	output int                                       awaiting,
	output int                                       reports_seen,
	output int                                       flips_seen,
	output int                                       press_reports,
	output int                                       clamp_reads
);
	timeunit 1ns;
	timeprecision 1ps;
	import pdenc_pkg::*;

	localparam int TRAVEL_TOP    = 2 ** (TOTAL_WIDTH - 1) - 1;
	localparam int TRAVEL_BOTTOM = -(2 ** (TOTAL_WIDTH - 1));
	localparam int PHASE_STEP [16] = '{
		0, -1, 1, 0, 1, 0, 0, -1,
		-1, 0, 0, 1, 0, 1, -1, 0
	};

	logic [COUNT_WIDTH-1:0]        debounce_setting;
	logic [SWITCH_COUNT-1:0]       settled;
	logic [SWITCH_COUNT-1:0]       pressed;
	logic [COUNT_WIDTH-1:0]        streak [SWITCH_COUNT];
	logic [PHASE_WIDTH-1:0]        prior_phase [ENCODER_COUNT];
	logic signed [TOTAL_WIDTH-1:0] travel [ENCODER_COUNT];
	result_t                       awaited_reports [$];
	result_t                       oldest;

	initial begin
		mismatches    = 0;
		awaiting      = 0;
		reports_seen  = 0;
		flips_seen    = 0;
		press_reports = 0;
		clamp_reads   = 0;
	end

	task automatic apply_poll_sample(
		input logic [SWITCH_COUNT-1:0]  lv,
		input logic [ENCODER_COUNT-1:0] ck,
		input logic [ENCODER_COUNT-1:0] dt,
		input logic [ENCODER_COUNT-1:0] td,
		input logic [SWITCH_COUNT-1:0]  tp
	);
		result_t                report;
		logic                   raw;
		logic [PHASE_WIDTH-1:0] phase;
		int                     sum;
		report = '0;
		for (int i = 0; i < SWITCH_COUNT; i++) begin
			if (tp[i]) begin
				report.press_mask[i] = pressed[i];
				pressed[i] = 1'b0;
			end
		end
		for (int e = 0; e < ENCODER_COUNT; e++) begin
			if (td[e]) begin
				report.deltas[e] = travel[e];
				travel[e] = '0;
			end
		end
		for (int i = 0; i < SWITCH_COUNT; i++) begin
			raw = ~lv[i];
			if (raw != settled[i]) begin
				if (streak[i] != COUNT_MAX)
					streak[i] = streak[i] + 1'b1;
				if (streak[i] >= debounce_setting) begin
					settled[i] = raw;
					streak[i] = '0;
					pressed[i] = raw;
					flips_seen++;
				end
			end else begin
				streak[i] = '0;
			end
		end
		for (int e = 0; e < ENCODER_COUNT; e++) begin
			phase = {ck[e], dt[e]};
			sum = int'(travel[e]) + PHASE_STEP[{prior_phase[e], phase}];
			if (sum > TRAVEL_TOP)
				sum = TRAVEL_TOP;
			else if (sum < TRAVEL_BOTTOM)
				sum = TRAVEL_BOTTOM;
			travel[e] = TOTAL_WIDTH'(sum);
			prior_phase[e] = phase;
		end
		report.held_mask = settled;
		awaited_reports.push_back(report);
	endtask

	function automatic void check_field(input string field, input int want, input int got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", field, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_setting = DEBOUNCE_RESET;
			settled = '0;
			pressed = '0;
			for (int i = 0; i < SWITCH_COUNT; i++)
				streak[i] = '0;
			for (int e = 0; e < ENCODER_COUNT; e++) begin
				prior_phase[e] = '0;
				travel[e] = '0;
			end
			awaited_reports.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (awaited_reports.size() == 0) begin
					$error("report arrived with no request outstanding");
					mismatches++;
				end else begin
					oldest = awaited_reports.pop_front();
					reports_seen++;
					check_field("held_mask", int'(oldest.held_mask), int'(held_mask));
					check_field("press_mask", int'(oldest.press_mask), int'(press_mask));
					check_field("delta_first", int'($signed(oldest.deltas[0])),
						int'(delta_first));
					check_field("delta_second", int'($signed(oldest.deltas[1])),
						int'(delta_second));
					check_field("delta_third", int'($signed(oldest.deltas[2])),
						int'(delta_third));
					if (press_mask != '0)
						press_reports++;
					for (int e = 0; e < ENCODER_COUNT; e++) begin
						if (int'($signed(oldest.deltas[e])) == TRAVEL_TOP ||
							int'($signed(oldest.deltas[e])) == TRAVEL_BOTTOM)
							clamp_reads++;
					end
				end
			end
			if (in_valid && !in_stall)
				apply_poll_sample(switch_levels, encoder_clock, encoder_data,
					take_delta_mask, take_press_mask);
			if (cfg_we)
				debounce_setting = cfg_wdata;
		end
		awaiting = awaited_reports.size();
	end

endmodule

### test/panel_switch_debounce_and_encoder_decode_top_tb.sv
module panel_switch_debounce_and_encoder_decode_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pdenc_pkg::*;

	localparam int LIMIT_CYCLES = 5_000_000;
	localparam int HOLD_CYCLES  = 80;
	localparam int CLAMP_RUN    = 40;
	localparam logic [PHASE_WIDTH-1:0] SPIN_UP   [4] = '{2'd2, 2'd0, 2'd3, 2'd1};
	localparam logic [PHASE_WIDTH-1:0] SPIN_DOWN [4] = '{2'd1, 2'd3, 2'd0, 2'd2};
	// octal digits: levels, clock, data, take delta, take press
	localparam logic [14:0] OPENING [25] = '{
		15'o70000, 15'o00077, 15'o00000, 15'o00007, 15'o00007,
		15'o07000, 15'o07700, 15'o00700, 15'o00070, 15'o00070,
		15'o07770, 15'o00070, 15'o00700, 15'o07710, 15'o77000,
		15'o70070, 15'o70007, 15'o60000, 15'o70000, 15'o65200,
		15'o62500, 15'o60001, 15'o70061, 15'o30005, 15'o77777
	};

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic [COUNT_WIDTH-1:0]        cfg_wdata;
	logic                          in_valid;
	logic                          in_stall;
	logic [SWITCH_COUNT-1:0]       switch_levels;
	logic [ENCODER_COUNT-1:0]      encoder_clock;
	logic [ENCODER_COUNT-1:0]      encoder_data;
	logic [ENCODER_COUNT-1:0]      take_delta_mask;
	logic [SWITCH_COUNT-1:0]       take_press_mask;
	logic                          out_valid;
	logic                          out_stall;
	logic [SWITCH_COUNT-1:0]       held_mask;
	logic [SWITCH_COUNT-1:0]       press_mask;
	logic signed [TOTAL_WIDTH-1:0] delta_first;
	logic signed [TOTAL_WIDTH-1:0] delta_second;
	logic signed [TOTAL_WIDTH-1:0] delta_third;

	int mismatches;
	int awaiting;
	int reports_seen;
	int flips_seen;
	int press_reports;
	int clamp_reads;

	int                     cycles;
	int                     polls_sent;
	int                     settings_tried;
	int                     send_gap_pct;
	int                     take_gap_pct;
	bit                     hold_asked;
	logic [SWITCH_COUNT-1:0] rest_level;
	logic [PHASE_WIDTH-1:0] drove_phase [ENCODER_COUNT];

	panel_switch_debounce_and_encoder_decode_top uut (.*);

	panel_report_checker report_check (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_asked) begin
				hold_asked = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else if (take_gap_pct != 0 && $urandom_range(0, 99) < take_gap_pct) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 19)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic offer_poll(
		input logic [SWITCH_COUNT-1:0]  lv,
		input logic [ENCODER_COUNT-1:0] ck,
		input logic [ENCODER_COUNT-1:0] dt,
		input logic [ENCODER_COUNT-1:0] td,
		input logic [SWITCH_COUNT-1:0]  tp
	);
		in_valid        <= 1'b1;
		switch_levels   <= lv;
		encoder_clock   <= ck;
		encoder_data    <= dt;
		take_delta_mask <= td;
		take_press_mask <= tp;
		do @(posedge clk); while (in_stall);
		for (int e = 0; e < ENCODER_COUNT; e++)
			drove_phase[e] = {ck[e], dt[e]};
		polls_sent++;
		if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	task automatic offer_random_poll(input int flip_span);
		logic [SWITCH_COUNT-1:0]  lv;
		logic [ENCODER_COUNT-1:0] ck;
		logic [ENCODER_COUNT-1:0] dt;
		logic [ENCODER_COUNT-1:0] td;
		logic [SWITCH_COUNT-1:0]  tp;
		logic [PHASE_WIDTH-1:0]   ph;
		int                       pick;
		int                       k;
		for (int i = 0; i < SWITCH_COUNT; i++) begin
			if ($urandom_range(0, flip_span) == 0)
				rest_level[i] = ~rest_level[i];
		end
		lv = rest_level;
		if ($urandom_range(0, 99) < 8) begin
			k = $urandom_range(0, SWITCH_COUNT - 1);
			lv[k] = ~lv[k];
		end
		for (int e = 0; e < ENCODER_COUNT; e++) begin
			pick = $urandom_range(0, 99);
			if (pick < 40)
				ph = SPIN_UP[drove_phase[e]];
			else if (pick < 70)
				ph = SPIN_DOWN[drove_phase[e]];
			else if (pick < 90)
				ph = drove_phase[e];
			else
				ph = PHASE_WIDTH'($urandom_range(0, 3));
			{ck[e], dt[e]} = ph;
		end
		td = ($urandom_range(0, 3) == 0) ? ENCODER_COUNT'($urandom_range(1, 7)) : '0;
		tp = ($urandom_range(0, 3) == 0) ? SWITCH_COUNT'($urandom_range(1, 7)) : '0;
		offer_poll(lv, ck, dt, td, tp);
	endtask

	task automatic settle;
		in_valid <= 1'b0;
		do @(negedge clk); while (awaiting != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_phase(input logic [COUNT_WIDTH-1:0] setting, input int polls,
		input bit squeeze);
		settle;
		cfg_we    <= 1'b1;
		cfg_wdata <= setting;
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_tried++;
		if (squeeze)
			hold_asked = 1'b1;
		repeat (polls) offer_random_poll(4 * int'(setting) + 4);
	endtask

	initial begin
		logic [ENCODER_COUNT-1:0] ck;
		logic [ENCODER_COUNT-1:0] dt;
		logic [PHASE_WIDTH-1:0]   ph;
		arst_n          <= 1'b0;
		cfg_we          <= 1'b0;
		cfg_wdata       <= '0;
		in_valid        <= 1'b0;
		switch_levels   <= '1;
		encoder_clock   <= '0;
		encoder_data    <= '0;
		take_delta_mask <= '0;
		take_press_mask <= '0;
		polls_sent      = 0;
		settings_tried  = 1;
		hold_asked      = 1'b0;
		rest_level      = '1;
		send_gap_pct    = 20;
		take_gap_pct    = 20;
		for (int e = 0; e < ENCODER_COUNT; e++)
			drove_phase[e] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (OPENING[k])
			offer_poll(OPENING[k][14:12], OPENING[k][11:9], OPENING[k][8:6],
				OPENING[k][5:3], OPENING[k][2:0]);

		// spin encoder 0 up and encoder 1 down, encoder 2 jumps
		send_gap_pct = 1;
		take_gap_pct = 1;
		repeat (CLAMP_RUN) begin
			for (int e = 0; e < ENCODER_COUNT; e++) begin
				if (e == 0)
					ph = SPIN_UP[drove_phase[e]];
				else if (e == 1)
					ph = SPIN_DOWN[drove_phase[e]];
				else
					ph = ~drove_phase[e];
				{ck[e], dt[e]} = ph;
			end
			offer_poll(SWITCH_COUNT'($urandom_range(0, 7)), ck, dt, '0,
				SWITCH_COUNT'($urandom_range(0, 7)));
		end
		for (int e = 0; e < ENCODER_COUNT; e++)
			{ck[e], dt[e]} = drove_phase[e];
		offer_poll(rest_level, ck, dt, '1, '1);

		send_gap_pct = 25;
		take_gap_pct = 25;
		run_phase(COUNT_WIDTH'(1), 70, 1'b1);
		run_phase(COUNT_WIDTH'(15), 80, 1'b0);
		run_phase(COUNT_WIDTH'(0), 60, 1'b0);
		run_phase(COUNT_WIDTH'($urandom_range(2, 14)), 70, 1'b0);
		send_gap_pct = 0;
		take_gap_pct = 0;
		run_phase(COUNT_WIDTH'(5), 60, 1'b0);
		settle;

		$display("Sent %0d poll samples under %0d debounce settings; %0d reports compared.",
			polls_sent, settings_tried, reports_seen);
		$display("Model saw %0d debounce flips, %0d press reports, %0d delta reads at a rail.",
			flips_seen, press_reports, clamp_reads);
		if (mismatches == 0 && awaiting == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

### files.f
+incdir+design
design/pdenc_pkg.sv
design/pdenc_switch_lane.sv
design/pdenc_encoder_lane.sv
design/pdenc_merge.sv
design/panel_switch_debounce_and_encoder_decode_top.sv
design/pdenc_checker.sv
test/panel_report_checker.sv
test/panel_switch_debounce_and_encoder_decode_top_tb.sv
